// ----- hw/rtl/sswd_pkg.sv -----
// Package for the SYN scan window detector: field widths, register indexes,
// result codes and the command / status bundles between controller and datapath.
// No dependencies.
`default_nettype none
package sswd_pkg;

  localparam int ADDR_W     = 32;
  localparam int PORT_W     = 16;
  localparam int TIME_W     = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int ALERT_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_LAN_LOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAN_HIGH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_US   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALERT_COUNT = 2'd3;

  localparam logic [31:0] LAN_LOW_RST     = 32'hAC10_0001;
  localparam logic [31:0] LAN_HIGH_RST    = 32'hAC20_FFFE;
  localparam logic [31:0] WINDOW_US_RST   = 32'd2000000;
  localparam logic [4:0]  ALERT_COUNT_RST = 5'd10;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_DROP,
    RES_CHECKED,
    RES_ALERT
  } res_sel_e;

  typedef struct packed {
    logic     cap_in;
    logic     cnt_clr;
    logic     src_rd;
    logic     new_src;
    logic     dup_rd;
    logic     append;
    logic     prune_rd;
    logic     prune_step;
    logic     src_wb;
    logic     res_load;
    res_sel_e res_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic gate_ok;
    logic src_last;
    logic found;
    logic free_ok;
    logic fill_zero;
    logic dup_last;
    logic dup;
    logic prune_go;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sswd_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module sswd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sswd_ctrl.sv -----
// Controller state machine of the SYN scan window detector.
// Depends on sswd_pkg for the command and status bundles.
`default_nettype none
module sswd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sswd_pkg::dp_stat_t stat_i,
  output sswd_pkg::dp_cmd_t      cmd_o
);
  import sswd_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_GATE = 4'd1;
  localparam logic [3:0] ST_SRC  = 4'd2;
  localparam logic [3:0] ST_SRCW = 4'd3;
  localparam logic [3:0] ST_SRCD = 4'd4;
  localparam logic [3:0] ST_DUP  = 4'd5;
  localparam logic [3:0] ST_DUPW = 4'd6;
  localparam logic [3:0] ST_DUPD = 4'd7;
  localparam logic [3:0] ST_APP  = 4'd8;
  localparam logic [3:0] ST_PRD  = 4'd9;
  localparam logic [3:0] ST_PRC  = 4'd10;
  localparam logic [3:0] ST_WB   = 4'd11;
  localparam logic [3:0] ST_DONE = 4'd12;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = ST_GATE;
        end
      end
      ST_GATE: begin
        if (stat_i.gate_ok) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_SRC;
        end else begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_ZERO;
          state_d        = ST_DONE;
        end
      end
      ST_SRC: begin
        cmd_o.src_rd = 1'b1;
        if (stat_i.src_last) begin
          state_d = ST_SRCW;
        end
      end
      ST_SRCW: state_d = ST_SRCD;
      ST_SRCD: begin
        if (stat_i.found) begin
          if (stat_i.fill_zero) begin
            state_d = ST_APP;
          end else begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = ST_DUP;
          end
        end else if (stat_i.free_ok) begin
          cmd_o.new_src  = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_CHECKED;
          state_d        = ST_DONE;
        end else begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_DROP;
          state_d        = ST_DONE;
        end
      end
      ST_DUP: begin
        cmd_o.dup_rd = 1'b1;
        if (stat_i.dup_last) begin
          state_d = ST_DUPW;
        end
      end
      ST_DUPW: state_d = ST_DUPD;
      ST_DUPD: begin
        if (stat_i.dup) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_CHECKED;
          state_d        = ST_DONE;
        end else begin
          state_d = ST_APP;
        end
      end
      ST_APP: begin
        cmd_o.append = 1'b1;
        state_d      = ST_PRD;
      end
      ST_PRD: begin
        cmd_o.prune_rd = 1'b1;
        state_d        = ST_PRC;
      end
      ST_PRC: begin
        if (stat_i.prune_go) begin
          cmd_o.prune_step = 1'b1;
          state_d          = ST_PRD;
        end else begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        cmd_o.src_wb   = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_ALERT;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sswd_dp.sv -----
// Datapath of the SYN scan window detector: input and config registers, scan
// counter, source and pair compares, ring arithmetic, pruning and output register.
// Depends on sswd_pkg; drives the source and entry RAMs instantiated at the top.
`default_nettype none
module sswd_dp #(
  parameter int SOURCES = 16,
  parameter int WINDOW  = 16,
  parameter int SIW     = (SOURCES > 1) ? $clog2(SOURCES) : 1,
  parameter int HW      = $clog2(WINDOW),
  parameter int FW      = $clog2(WINDOW + 1),
  parameter int EAW     = $clog2(SOURCES * WINDOW),
  parameter int SRW     = 32 + HW + FW,
  parameter int ERW     = 96
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire sswd_pkg::dp_cmd_t            cmd_i,
  output sswd_pkg::dp_stat_t                stat_o,
  input  wire logic [127:0]                 in_data_i,
  input  wire logic [1:0]                   in_user_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [sswd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sswd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                              src_we_o,
  output logic [SIW-1:0]                    src_waddr_o,
  output logic [SRW-1:0]                    src_wdata_o,
  output logic [SIW-1:0]                    src_raddr_o,
  input  wire logic [SRW-1:0]               src_rdata_i,
  output logic                              ent_we_o,
  output logic [EAW-1:0]                    ent_waddr_o,
  output logic [ERW-1:0]                    ent_wdata_o,
  output logic [EAW-1:0]                    ent_raddr_o,
  input  wire logic [ERW-1:0]               ent_rdata_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [2:0]                        out_res_o
);
  import sswd_pkg::*;

  localparam int CW = (SIW > HW) ? SIW : HW;
  localparam int LW = (CW + 1 > FW) ? CW + 1 : FW;

  function automatic logic [HW-1:0] wrap(input logic [HW:0] a);
    if (a >= (HW+1)'(WINDOW)) begin
      return HW'(a - (HW+1)'(WINDOW));
    end
    return a[HW-1:0];
  endfunction

  // captured request
  logic [31:0] src_q, dst_q;
  logic [15:0] port_q;
  logic [47:0] time_q;
  logic        syn_q, ack_q;

  logic [31:0] lan_lo_q, lan_hi_q, win_q;
  logic [4:0]  alert_q;

  logic [CW-1:0]  cnt_q;
  logic           src_cmp_q, dup_cmp_q;
  logic [SIW-1:0] cmp_idx_q;
  logic           found_q, free_ok_q, dup_q;
  logic [SIW-1:0] fidx_q, free_idx_q;
  logic [HW-1:0]  head_q;
  logic [FW-1:0]  fill_q;
  logic [SOURCES-1:0] used_q;
  logic [2:0]     res_q;
  logic           out_valid_q;
  logic [2:0]     out_res_q;

  logic [31:0]    rd_key;
  logic [HW-1:0]  rd_head;
  logic [FW-1:0]  rd_fill;
  logic [31:0]    e_dst;
  logic [15:0]    e_port;
  logic [47:0]    e_time, age;
  logic [EAW-1:0] base_f, base_n;
  logic [HW-1:0]  dup_slot, app_head, app_slot;
  logic [FW-1:0]  app_fill;
  logic           ring_full;
  logic [CW:0]    cnt_p1;

  assign rd_key  = src_rdata_i[SRW-1 -: 32];
  assign rd_head = src_rdata_i[HW+FW-1:FW];
  assign rd_fill = src_rdata_i[FW-1:0];
  assign e_dst   = ent_rdata_i[95:64];
  assign e_port  = ent_rdata_i[63:48];
  assign e_time  = ent_rdata_i[47:0];

  assign base_f    = EAW'(fidx_q * WINDOW);
  assign base_n    = EAW'(free_idx_q * WINDOW);
  assign dup_slot  = wrap({1'b0, head_q} + {1'b0, cnt_q[HW-1:0]});
  assign ring_full = fill_q >= FW'(WINDOW);
  assign app_head  = ring_full ? wrap({1'b0, head_q} + (HW+1)'(1)) : head_q;
  assign app_fill  = ring_full ? FW'(WINDOW - 1) : fill_q;
  assign app_slot  = wrap({1'b0, app_head} + (HW+1)'(app_fill));
  assign age       = (time_q > e_time) ? (time_q - e_time) : '0;
  assign cnt_p1    = {1'b0, cnt_q} + (CW+1)'(1);

  assign stat_o.gate_ok   = syn_q && !ack_q && (lan_lo_q <= dst_q) && (dst_q <= lan_hi_q);
  assign stat_o.src_last  = cnt_q == CW'(SOURCES - 1);
  assign stat_o.found     = found_q;
  assign stat_o.free_ok   = free_ok_q;
  assign stat_o.fill_zero = fill_q == '0;
  assign stat_o.dup_last  = LW'(cnt_p1) >= LW'(fill_q);
  assign stat_o.dup       = dup_q;
  assign stat_o.prune_go  = (fill_q != '0) && (age > {16'd0, win_q});
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // source table ports
  assign src_raddr_o = cnt_q[SIW-1:0];
  assign src_we_o    = cmd_i.new_src || cmd_i.src_wb;
  assign src_waddr_o = cmd_i.new_src ? free_idx_q : fidx_q;
  assign src_wdata_o = cmd_i.new_src ? {src_q, HW'(0), FW'(1)} : {src_q, head_q, fill_q};

  // entry ring ports
  assign ent_we_o    = cmd_i.new_src || cmd_i.append;
  assign ent_waddr_o = cmd_i.new_src ? base_n : base_f + EAW'(app_slot);
  assign ent_wdata_o = {dst_q, port_q, time_q};
  assign ent_raddr_o = cmd_i.prune_rd ? base_f + EAW'(head_q) : base_f + EAW'(dup_slot);

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      src_q  <= in_data_i[31:0];
      dst_q  <= in_data_i[63:32];
      port_q <= in_data_i[79:64];
      time_q <= in_data_i[127:80];
      syn_q  <= in_user_i[0];
      ack_q  <= in_user_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lan_lo_q <= LAN_LOW_RST;
      lan_hi_q <= LAN_HIGH_RST;
      win_q    <= WINDOW_US_RST;
      alert_q  <= ALERT_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LAN_LOW:     lan_lo_q <= cfg_data_i;
        REG_LAN_HIGH:    lan_hi_q <= cfg_data_i;
        REG_WINDOW_US:   win_q    <= cfg_data_i;
        REG_ALERT_COUNT: alert_q  <= cfg_data_i[ALERT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      src_cmp_q   <= 1'b0;
      dup_cmp_q   <= 1'b0;
      cmp_idx_q   <= '0;
      found_q     <= 1'b0;
      free_ok_q   <= 1'b0;
      dup_q       <= 1'b0;
      fidx_q      <= '0;
      free_idx_q  <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      used_q      <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      src_cmp_q <= cmd_i.src_rd;
      dup_cmp_q <= cmd_i.dup_rd;
      if (cmd_i.src_rd) begin
        cmp_idx_q <= cnt_q[SIW-1:0];
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.src_rd || cmd_i.dup_rd) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.cap_in) begin
        found_q   <= 1'b0;
        free_ok_q <= 1'b0;
        dup_q     <= 1'b0;
      end
      // compare stage of the source scan, one read behind the counter
      if (src_cmp_q) begin
        if (used_q[cmp_idx_q]) begin
          if (!found_q && rd_key == src_q) begin
            found_q <= 1'b1;
            fidx_q  <= cmp_idx_q;
            head_q  <= rd_head;
            fill_q  <= rd_fill;
          end
        end else if (!free_ok_q) begin
          free_ok_q  <= 1'b1;
          free_idx_q <= cmp_idx_q;
        end
      end
      if (dup_cmp_q && e_dst == dst_q && e_port == port_q) begin
        dup_q <= 1'b1;
      end
      if (cmd_i.new_src) begin
        used_q[free_idx_q] <= 1'b1;
      end
      if (cmd_i.append) begin
        head_q <= app_head;
        fill_q <= app_fill + FW'(1);
      end else if (cmd_i.prune_step) begin
        head_q <= wrap({1'b0, head_q} + (HW+1)'(1));
        fill_q <= fill_q - FW'(1);
      end
      if (cmd_i.res_load) begin
        case (cmd_i.res_sel)
          RES_ZERO:    res_q <= 3'b000;
          RES_DROP:    res_q <= 3'b110;
          RES_CHECKED: res_q <= 3'b010;
          RES_ALERT:   res_q <= {2'b01, 32'(fill_q) >= 32'(alert_q)};
          default:     res_q <= 3'b000;
        endcase
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        out_res_q   <= res_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/syn_scan_window_detector_core.sv -----
// Top level of the SYN scan window detector: controller, datapath, source table
// RAM and entry ring RAM. Depends on sswd_pkg, sswd_ctrl, sswd_dp and sswd_ram.
//
// One packet header summary is taken at a time and gives exactly one result.
// A packet that fails the SYN-only LAN gate goes straight to the result.
// A checked packet scans the source table one entry a cycle; a new source is
// stored with its first entry, or dropped when the table is full. A known
// source's ring is compared one entry a cycle, then, unless a duplicate is
// found, the entry is appended, entries older than the window are pruned and
// the source is written back. Each RAM has a single read port, so the scans
// read one entry at a time. The result waits in an output register so the
// next packet can be accepted while it is pending.
`default_nettype none
module syn_scan_window_detector_core #(
  parameter int SOURCES = 16,
  parameter int WINDOW  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // src_addr, dst_addr, dst_port, time_us
  input  wire logic [1:0]  s_axis_tuser,   // syn_flag, ack_flag
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // scan_alert, zero fill
  output logic [1:0]       m_axis_tuser,   // was_checked, source_dropped
  input  wire logic        cfg_we_i,
  input  wire logic [sswd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sswd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sswd_pkg::*;

  localparam int SIW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int HW  = $clog2(WINDOW);
  localparam int FW  = $clog2(WINDOW + 1);
  localparam int EAW = $clog2(SOURCES * WINDOW);
  localparam int SRW = ADDR_W + HW + FW;
  localparam int ERW = ADDR_W + PORT_W + TIME_W;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic           src_we, ent_we;
  logic [SIW-1:0] src_waddr, src_raddr;
  logic [SRW-1:0] src_wdata, src_rdata;
  logic [EAW-1:0] ent_waddr, ent_raddr;
  logic [ERW-1:0] ent_wdata, ent_rdata;
  logic [2:0]     res;

  sswd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sswd_dp #(
    .SOURCES (SOURCES),
    .WINDOW  (WINDOW),
    .SIW     (SIW),
    .HW      (HW),
    .FW      (FW),
    .EAW     (EAW),
    .SRW     (SRW),
    .ERW     (ERW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .src_we_o    (src_we),
    .src_waddr_o (src_waddr),
    .src_wdata_o (src_wdata),
    .src_raddr_o (src_raddr),
    .src_rdata_i (src_rdata),
    .ent_we_o    (ent_we),
    .ent_waddr_o (ent_waddr),
    .ent_wdata_o (ent_wdata),
    .ent_raddr_o (ent_raddr),
    .ent_rdata_i (ent_rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  sswd_ram #(.WIDTH(SRW), .DEPTH(SOURCES)) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (src_waddr),
    .wdata_i (src_wdata),
    .raddr_i (src_raddr),
    .rdata_o (src_rdata)
  );

  sswd_ram #(.WIDTH(ERW), .DEPTH(SOURCES * WINDOW)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  // res holds {source_dropped, was_checked, scan_alert}
  assign m_axis_tdata = {7'd0, res[0]};
  assign m_axis_tuser = res[2:1];

endmodule
`default_nettype wire

// ----- hw/rtl/sswd_checker.sv -----
// Port-level checks for the SYN scan window detector, bound to the top level.
// Depends only on the top level's handshake and result ports.
`default_nettype none
module sswd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // an alert only comes from a checked packet
  a_alert_checked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && !m_axis_tuser[0]))
    else $error("alert without check");

  // a dropped source is checked and never alerts
  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] && !m_axis_tdata[0])
    else $error("bad dropped-source result");

  // one request at a time: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while busy");

endmodule

bind syn_scan_window_detector_core sswd_checker u_sswd_checker (.*);
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for syn_scan_window_detector_core: drives packet header summaries and
// register writes, predicts alert / checked / dropped flags per packet.
// Depends on sswd_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none

class scan_scoreboard;
  localparam int NSRC = 16;
  localparam int NWIN = 16;

  logic [31:0] lan_lo, lan_hi, win_us;
  logic [4:0]  alert_thr;
  logic [31:0] key[NSRC];
  bit          used[NSRC];
  logic [31:0] e_dst[NSRC][NWIN];
  logic [15:0] e_port[NSRC][NWIN];
  logic [47:0] e_time[NSRC][NWIN];
  int unsigned head[NSRC];
  int unsigned fill[NSRC];
  logic [2:0]  flag_q[$];   // {dropped, checked, alert}
  int          errors;

  function new();
    lan_lo = sswd_pkg::LAN_LOW_RST;
    lan_hi = sswd_pkg::LAN_HIGH_RST;
    win_us = sswd_pkg::WINDOW_US_RST;
    alert_thr = sswd_pkg::ALERT_COUNT_RST;
    errors = 0;
    for (int s = 0; s < NSRC; s++) begin
      used[s] = 0;
      head[s] = 0;
      fill[s] = 0;
    end
  endfunction

  function void add_flag(logic [2:0] f);
    flag_q.insert(flag_q.size(), f);
  endfunction

  function logic [2:0] take_flag();
    logic [2:0] f;
    f = flag_q[0];
    flag_q.delete(0);
    return f;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      sswd_pkg::REG_LAN_LOW:     lan_lo = val;
      sswd_pkg::REG_LAN_HIGH:    lan_hi = val;
      sswd_pkg::REG_WINDOW_US:   win_us = val;
      sswd_pkg::REG_ALERT_COUNT: alert_thr = val[4:0];
      default: ;
    endcase
  endfunction

  function void note_packet(logic [31:0] src, logic [31:0] dst, logic [15:0] port,
                            logic syn, logic ack, logic [47:0] now);
    int found, free_s, s, k;
    logic [47:0] t, age;
    found = -1;
    free_s = -1;
    if (!(syn && !ack && lan_lo <= dst && dst <= lan_hi)) begin
      add_flag(3'b000);
      return;
    end
    for (s = 0; s < NSRC; s++) begin
      if (used[s]) begin
        if (found < 0 && key[s] == src) found = s;
      end else if (free_s < 0) free_s = s;
    end
    if (found < 0) begin
      if (free_s < 0) begin
        add_flag(3'b110);
        return;
      end
      used[free_s] = 1;
      key[free_s] = src;
      head[free_s] = 0;
      fill[free_s] = 1;
      e_dst[free_s][0] = dst;
      e_port[free_s][0] = port;
      e_time[free_s][0] = now;
      add_flag(3'b010);
      return;
    end
    s = found;
    for (int i = 0; i < fill[s]; i++) begin
      k = (head[s] + i) % NWIN;
      if (e_dst[s][k] == dst && e_port[s][k] == port) begin
        add_flag(3'b010);
        return;
      end
    end
    if (fill[s] >= NWIN) begin
      head[s] = (head[s] + 1) % NWIN;
      fill[s] = NWIN - 1;
    end
    k = (head[s] + fill[s]) % NWIN;
    e_dst[s][k] = dst;
    e_port[s][k] = port;
    e_time[s][k] = now;
    fill[s]++;
    while (fill[s] > 0) begin
      t = e_time[s][head[s]];
      age = (now > t) ? now - t : 48'd0;
      if (age > {16'd0, win_us}) begin
        head[s] = (head[s] + 1) % NWIN;
        fill[s]--;
      end else break;
    end
    add_flag({2'b01, fill[s] >= alert_thr});
  endfunction

  function void check_result(logic alert, logic checked, logic dropped);
    logic [2:0] exp_f;
    if (flag_q.size() == 0) begin
      $error("unexpected result alert=%0d checked=%0d dropped=%0d",
             alert, checked, dropped);
      errors++;
      return;
    end
    exp_f = take_flag();
    if (alert !== exp_f[0]) begin
      $error("scan_alert expected %0d got %0d", exp_f[0], alert);
      errors++;
    end
    if (checked !== exp_f[1]) begin
      $error("was_checked expected %0d got %0d", exp_f[1], checked);
      errors++;
    end
    if (dropped !== exp_f[2]) begin
      $error("source_dropped expected %0d got %0d", exp_f[2], dropped);
      errors++;
    end
  endfunction
endclass

module tb;
  import sswd_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [7:0]   m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_we_i = 0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  scan_scoreboard sb = new();
  logic [47:0] clock_us = 0;
  bit          quiet = 0;      // no idling in the last part
  bit          hold_sink = 0;
  int          idle_cycles = 0;
  logic [31:0] host_pool[8];

  syn_scan_window_detector_core u_top (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata[0], m_axis_tuser[0], m_axis_tuser[1]);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // result side: random stall bursts, or a long hold when asked
  initial begin
    int burst;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 0;
        repeat (300) @(posedge clk_i);
        hold_sink = 0;
        m_axis_tready <= 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 5);
        m_axis_tready <= 0;
        repeat (burst - 1) @(posedge clk_i);
      end else m_axis_tready <= 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    while (sb.flag_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic send_packet(logic [31:0] src, logic [31:0] dst, logic [15:0] port,
                             logic syn, logic ack, logic [47:0] now);
    // valid drops between requests
    @(posedge clk_i);
    if (!quiet && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {now, port, dst, src};
    s_axis_tuser <= {ack, syn};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_packet(src, dst, port, syn, ack, now);
    s_axis_tvalid <= 0;
  endtask

  // mostly in-range SYNs from a small pool of hosts, time moving slowly
  task automatic random_packet(logic [31:0] lo, logic [31:0] hi);
    logic [31:0] src, dst;
    logic [15:0] port;
    logic        syn, ack;
    logic [47:0] now;
    int          r;
    r = $urandom_range(0, 99);
    src = (r < 85) ? host_pool[$urandom_range(0, 7)] : $urandom;
    dst = (r % 10 < 8 && hi >= lo) ? lo + $urandom_range(0, 5) : $urandom;
    port = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(20, 40));
    syn = ($urandom_range(0, 9) != 0);
    ack = ($urandom_range(0, 9) == 0);
    clock_us = clock_us + $urandom_range(0, 300);
    now = clock_us;
    if ($urandom_range(0, 49) == 0) now = clock_us - $urandom_range(0, 2000);
    send_packet(src, dst, port, syn, ack, now);
  endtask

  initial begin
    logic [31:0] lo;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    for (int i = 0; i < 8; i++) host_pool[i] = $urandom;
    @(posedge clk_i);

    // directed: gate edges, flags, duplicates, new sources, table full
    send_packet(32'h1, LAN_LOW_RST, 16'h0, 1, 0, 48'd0);
    send_packet(32'h1, LAN_LOW_RST - 1, 16'h1, 1, 0, 48'd1);
    send_packet(32'h1, LAN_HIGH_RST, 16'hFFFF, 1, 0, 48'd2);
    send_packet(32'h1, LAN_HIGH_RST + 1, 16'h2, 1, 0, 48'd3);
    send_packet(32'h1, LAN_LOW_RST, 16'h0, 1, 0, 48'd4);
    send_packet(32'h1, LAN_LOW_RST, 16'h5, 1, 1, 48'd5);
    send_packet(32'h1, LAN_LOW_RST, 16'h6, 0, 0, 48'd6);
    send_packet(32'h1, LAN_LOW_RST, 16'h7, 0, 1, 48'd7);
    for (int s = 2; s <= 17; s++)
      send_packet(s == 17 ? 32'hFFFF_FFFF : 32'(s), LAN_LOW_RST, 16'(s), 1, 0, 48'd8);
    send_packet(32'h1, LAN_LOW_RST + 1, 16'h0, 1, 0, 48'hFFFF_FFFF_FFFF);
    drain();

    // registers: extremes then random settings, fresh state via new sources
    write_reg(REG_ALERT_COUNT, 32'd0);
    write_reg(REG_WINDOW_US, 32'hFFFF_FFFF);
    write_reg(REG_LAN_LOW, 32'h0);
    write_reg(REG_LAN_HIGH, 32'hFFFF_FFFF);
    for (int i = 0; i < 20; i++)
      send_packet(32'h1, $urandom, 16'($urandom), 1, 0, 48'hFFFF_FFFF_FFFF);
    drain();
    write_reg(REG_LAN_LOW, 32'h10);
    write_reg(REG_LAN_HIGH, 32'h0F);
    send_packet(32'h1, 32'h10, 16'h0, 1, 0, 48'd0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      lo = $urandom;
      write_reg(REG_LAN_LOW, lo);
      write_reg(REG_LAN_HIGH, (lo > 32'hFFFF_FF00) ? 32'hFFFF_FFFF : lo + 32'd50);
      write_reg(REG_WINDOW_US, phase == 0 ? 32'd1 : $urandom_range(200, 6000));
      write_reg(REG_ALERT_COUNT, phase == 1 ? 32'd16 : phase == 2 ? 32'd17 :
                $urandom_range(1, 31));
      for (int i = 0; i < 8; i++) host_pool[i] = $urandom;
      for (int n = 0; n < 200; n++) begin
        if (phase == 3 && n == 50) hold_sink = 1;
        if (phase == 4 && n == 100) drain();
        if (phase == 5 && n == 120) quiet = 1;
        random_packet(sb.lan_lo, sb.lan_hi);
      end
      drain();
    end

    while (sb.flag_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

`default_nettype wire
